// ===== rtl/sqr_pkg.sv =====
// ============================================================================
// Square matrix rotator package
// Shared constants, codes and types of the square matrix rotator.
// ============================================================================
package sqr_pkg;

    // Default parameter values of the top level
    localparam int SIDE_MAX_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int ELEM_W    = 16;
    localparam int KIND_W    = 2;
    localparam int SIZE_W    = 5;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd1;

    // Transform kinds; the unused code behaves as the ring shift
    localparam logic [KIND_W-1:0] KIND_ROT90  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROT180 = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RING   = 2'd2;

    // Register reset values
    localparam logic [KIND_W-1:0] KIND_RESET = KIND_ROT90;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // Item modes carried in tuser
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic {
        PH_LOAD,
        PH_DRAIN
    } phase_t;

    // Store access strobes from the controller
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

endpackage

// ===== rtl/square_matrix_rotator.sv =====
// ============================================================================
// Square matrix rotator
// Loads an N by N matrix row by row and drains it rotated 90 or 180 degrees
// clockwise, or with every ring shifted one place clockwise.
//
// Channel   Direction  Payload
// s_*       in         tuser: mode; tdata: value
// m_*       out        tdata: element; tlast: last
// cfg_*     in         cfg_index: register; cfg_data: register value
//
// A drained element shows on m_* the cycle after its request, read straight
// from the store's registered read port. A new item is taken whenever the output
// is empty or being taken, so loads and drains run at one item per cycle while
// the receiver keeps up; a result that waits on m_tready holds off every input
// item, loads included. Reset clears the counters and sets the registers to
// their reset values; the store keeps no reset and needs no clearing pass since
// every drained entry was loaded first.
// ============================================================================
module square_matrix_rotator #(
    parameter int SIDE_MAX   = sqr_pkg::SIDE_MAX_DEF,
    parameter int DATA_WIDTH = sqr_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [sqr_pkg::ELEM_W-1:0]   s_tdata,   // [15:0] value
    input  logic                                s_tuser,   // [0] mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [sqr_pkg::ELEM_W-1:0]   m_tdata,   // [15:0] element
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sqr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sqr_pkg::SIZE_W-1:0]          cfg_data
);
    import sqr_pkg::*;

    localparam int DEPTH = SIDE_MAX * SIDE_MAX;
    localparam int CW    = (SIDE_MAX > 1) ? $clog2(SIDE_MAX) : 1;
    localparam int SW    = $clog2(SIDE_MAX + 1);
    localparam int AW    = (SIDE_MAX > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int EW    = DATA_WIDTH + ELEM_W;

    logic [KIND_W-1:0]     rotation_kind_reg;
    logic [SIZE_W-1:0]     matrix_size_reg;
    logic                  size_wr;
    logic [SW-1:0]         side;
    store_ctl_t            ctl;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [CW-1:0]         row;
    logic [CW-1:0]         col;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [EW-1:0]         value_zx;
    logic [EW-1:0]         elem_sx;

    assign cfg_ready = 1'b1;
    assign size_wr   = cfg_valid && (cfg_index == CFG_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_kind_reg <= KIND_RESET;
            matrix_size_reg   <= SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_KIND)
            begin
                rotation_kind_reg <= cfg_data[KIND_W-1:0];
            end
            else if (cfg_index == CFG_SIZE)
            begin
                matrix_size_reg <= cfg_data;
            end
        end
    end

    // A size of zero acts as one; sizes above the maximum are clipped.
    always_comb
    begin
        if (matrix_size_reg == '0)
        begin
            side = SW'(1);
        end
        else if (32'(matrix_size_reg) > SIDE_MAX)
        begin
            side = SW'(SIDE_MAX);
        end
        else
        begin
            side = SW'(matrix_size_reg);
        end
    end

    sqr_ctrl #(
        .CW (CW),
        .SW (SW),
        .AW (AW),
        .LW (LW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .size_wr  (size_wr),
        .side     (side),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .ctl      (ctl),
        .wr_addr  (wr_addr),
        .row      (row),
        .col      (col)
    );

    sqr_addr_gen #(
        .CW (CW),
        .SW (SW),
        .AW (AW)
    ) u_addr_gen (
        .kind (rotation_kind_reg),
        .side (side),
        .row  (row),
        .col  (col),
        .addr (rd_addr)
    );

    // Loaded values keep their low bits; wider elements are zero-extended.
    assign value_zx = {{DATA_WIDTH{1'b0}}, s_tdata};

    sqr_store #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_store (
        .clk     (clk),
        .ctl     (ctl),
        .wr_addr (wr_addr),
        .wr_data (value_zx[DATA_WIDTH-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign elem_sx = {{ELEM_W{rd_data[DATA_WIDTH-1]}}, rd_data};
    assign m_tdata = elem_sx[ELEM_W-1:0];

endmodule

// ===== rtl/sqr_store.sv =====
// ============================================================================
// Matrix store
// Single-port-write, single-port-read memory with a registered read port.
// ============================================================================
module sqr_store #(
    parameter int DATA_WIDTH = 16,
    parameter int DEPTH      = 256,
    parameter int AW         = 8
) (
    input  logic                   clk,
    input  sqr_pkg::store_ctl_t    ctl,
    input  logic [AW-1:0]          wr_addr,
    input  logic [DATA_WIDTH-1:0]  wr_data,
    input  logic [AW-1:0]          rd_addr,
    output logic [DATA_WIDTH-1:0]  rd_data
);
    import sqr_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read, so it doubles as the output register.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sqr_addr_gen.sv =====
// ============================================================================
// Source address generator
// Maps an output position to the store address of its source element.
// ============================================================================
module sqr_addr_gen #(
    parameter int CW = 4,
    parameter int SW = 5,
    parameter int AW = 8
) (
    input  logic [sqr_pkg::KIND_W-1:0] kind,
    input  logic [SW-1:0]              side,
    input  logic [CW-1:0]              row,
    input  logic [CW-1:0]              col,
    output logic [AW-1:0]              addr
);
    import sqr_pkg::*;

    localparam int PW = CW + SW;

    logic [CW-1:0] nm1;
    logic [CW-1:0] row_m;
    logic [CW-1:0] col_m;
    logic [CW-1:0] min_a;
    logic [CW-1:0] min_b;
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
    logic [CW-1:0] src_row;
    logic [CW-1:0] src_col;
    logic [PW-1:0] prod;
    logic [PW-1:0] sum;

    assign nm1   = CW'(side - SW'(1));
    assign row_m = nm1 - row;
    assign col_m = nm1 - col;
    assign min_a = (row < col) ? row : col;
    assign min_b = (row_m < col_m) ? row_m : col_m;
    assign lo    = (min_a < min_b) ? min_a : min_b;
    assign hi    = nm1 - lo;

    always_comb
    begin
        case (kind)
            KIND_ROT90:
            begin
                src_row = col_m;
                src_col = row;
            end
            KIND_ROT180:
            begin
                src_row = row_m;
                src_col = col_m;
            end
            default:
            begin
                // Ring shift: each element takes its counterclockwise neighbor.
                src_row = row;
                src_col = col;
                if (lo == hi)
                begin
                    src_row = row;
                end
                else if (row == lo && col > lo)
                begin
                    src_col = col - CW'(1);
                end
                else if (col == hi && row > lo)
                begin
                    src_row = row - CW'(1);
                end
                else if (row == hi && col < hi)
                begin
                    src_col = col + CW'(1);
                end
                else
                begin
                    src_row = row + CW'(1);
                end
            end
        endcase
    end

    assign prod = PW'(src_row) * PW'(side);
    assign sum  = prod + PW'(src_col);
    assign addr = sum[AW-1:0];

endmodule

// ===== rtl/sqr_ctrl.sv =====
// ============================================================================
// Load and drain controller
// Tracks the load count and drain position and owns the output handshake.
// ============================================================================
module sqr_ctrl #(
    parameter int CW = 4,
    parameter int SW = 5,
    parameter int AW = 8,
    parameter int LW = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  size_wr,
    input  logic [SW-1:0]         side,
    input  logic                  s_tvalid,
    input  logic                  mode,
    output logic                  s_tready,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic                  m_tlast,
    output sqr_pkg::store_ctl_t   ctl,
    output logic [AW-1:0]         wr_addr,
    output logic [CW-1:0]         row,
    output logic [CW-1:0]         col
);
    import sqr_pkg::*;

    phase_t        phase_reg, phase_next;
    logic [LW-1:0] load_count_reg, load_count_next;
    logic [CW-1:0] out_row_reg, out_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_last_reg, out_last_next;

    logic [LW-1:0] total;
    logic [CW-1:0] nm1;
    logic          load_full;
    logic          row_last;
    logic          col_last;
    logic          accept;
    logic          fin;

    assign total     = LW'(side) * LW'(side);
    assign nm1       = CW'(side - SW'(1));
    assign load_full = (load_count_reg >= total);
    assign row_last  = (out_row_reg == nm1);
    assign col_last  = (out_col_reg == nm1);
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LOAD;
            load_count_reg <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            load_count_reg <= load_count_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        load_count_next = load_count_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        ctl             = '0;
        fin             = 1'b0;

        if (size_wr)
        begin
            phase_next      = PH_LOAD;
            load_count_next = '0;
            out_row_next    = '0;
            out_col_next    = '0;
        end
        else if (accept)
        begin
            if (mode == MODE_LOAD)
            begin
                if (phase_reg == PH_LOAD && !load_full)
                begin
                    ctl.wr_en       = 1'b1;
                    load_count_next = load_count_reg + LW'(1);
                end
            end
            else if (load_full)
            begin
                // Position registers sit at zero during loading, so the first
                // drained item reads from the top left of the output.
                ctl.rd_en = 1'b1;
                fin       = row_last && col_last;
                if (fin)
                begin
                    phase_next      = PH_LOAD;
                    load_count_next = '0;
                    out_row_next    = '0;
                    out_col_next    = '0;
                end
                else
                begin
                    phase_next = PH_DRAIN;
                    if (col_last)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + CW'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + CW'(1);
                    end
                end
            end
        end

        if (ctl.rd_en)
        begin
            out_valid_next = 1'b1;
            out_last_next  = fin;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_tready;
            out_last_next  = out_last_reg;
        end
    end

    assign wr_addr  = load_count_reg[AW-1:0];
    assign row      = out_row_reg;
    assign col      = out_col_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= total)
        else $error("load count passed the matrix size");

    a_drain_full: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DRAIN) |-> load_full)
        else $error("draining without a complete matrix");

    a_fin_return: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.rd_en && fin) |=> (phase_reg == PH_LOAD && load_count_reg == '0
                                && out_last_reg && out_valid_reg))
        else $error("final item did not return to loading");

endmodule
